@@ rtl/core/segment_intersection_point_macros.svh @@
// ----------------------------------------------------------------------------
// segment intersection point assertion macros
// shared concurrent property wrappers clocked on clock, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_POINT_MACROS_SVH
`define SEGMENT_INTERSECTION_POINT_MACROS_SVH

// same-cycle implication
`define SIP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SIP_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/sip_pkg.sv @@
// ----------------------------------------------------------------------------
// sip_pkg
// shared types and codes of the segment intersection point pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package sip_pkg;

   localparam int QW      = 16;   // quotient bits of t and u
   localparam int MW      = 65;   // magnitude width of determinant and numerators
   localparam int DIV_LEN = 16;   // one restoring step per stage

   localparam logic [1:0] VERDICT_PARALLEL = 2'd0;
   localparam logic [1:0] VERDICT_NONE     = 2'd1;
   localparam logic [1:0] VERDICT_CROSS    = 2'd2;

   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_MARGIN    = 1'b1;

   typedef struct packed {
      logic valid;
      logic parallel;
      logic fail;
   } sip_tag_type;

   typedef struct packed {
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [32:0] rx;
      logic signed [32:0] ry;
   } sip_carry_type;

   typedef struct packed {
      logic [MW-1:0] den;
      logic [MW-1:0] rem_t;
      logic [MW-1:0] rem_u;
      logic [QW-1:0] q_t;
      logic [QW-1:0] q_u;
   } sip_div_type;

endpackage

`default_nettype wire

@@ rtl/core/sip_front.sv @@
// ----------------------------------------------------------------------------
// sip_front
// differences, cross products, magnitudes and early verdict flags (7 stages)
// ----------------------------------------------------------------------------
`default_nettype none

module sip_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire logic                 in_valid,
   input  wire logic signed [31:0]   ax,
   input  wire logic signed [31:0]   ay,
   input  wire logic signed [31:0]   bx,
   input  wire logic signed [31:0]   by,
   input  wire logic signed [31:0]   cx,
   input  wire logic signed [31:0]   cy,
   input  wire logic signed [31:0]   dx,
   input  wire logic signed [31:0]   dy,
   input  wire logic [31:0]          threshold,
   output sip_pkg::sip_tag_type      tag_out,
   output sip_pkg::sip_carry_type    carry_out,
   output sip_pkg::sip_div_type      div_out
);
   import sip_pkg::*;

   function automatic logic [31:0] mag33(input logic signed [32:0] v);
      logic signed [32:0] n;
      begin
         n = -v;
         mag33 = v[32] ? n[31:0] : v[31:0];
      end
   endfunction

   function automatic logic [MW-1:0] mag66(input logic signed [65:0] v);
      logic signed [65:0] n;
      begin
         n = -v;
         mag66 = v[65] ? n[MW-1:0] : v[MW-1:0];
      end
   endfunction

   function automatic logic signed [65:0] apply_sign(input logic neg, input logic [63:0] p);
      logic signed [65:0] e;
      begin
         e = $signed({2'b00, p});
         apply_sign = neg ? -e : e;
      end
   endfunction

   logic [5:0] v_ff;

   // stage 1: edge vectors
   logic signed [32:0] rx1_ff, ry1_ff, sx1_ff, sy1_ff, wx1_ff, wy1_ff;
   logic signed [31:0] ax1_ff, ay1_ff;
   // stage 2: magnitudes and signs
   logic [31:0] mrx2_ff, mry2_ff, msx2_ff, msy2_ff, mwx2_ff, mwy2_ff;
   logic [5:0]  sg2_ff;
   sip_carry_type c2_ff, c3_ff, c4_ff, c5_ff, c6_ff, c7_ff;
   // stage 3: six products
   logic [63:0] pd_a3_ff, pd_b3_ff, pt_a3_ff, pt_b3_ff, pu_a3_ff, pu_b3_ff;
   logic [5:0]  ng3_ff;
   logic [63:0] pd_a, pd_b, pt_a, pt_b, pu_a, pu_b;
   // stage 4: signed terms
   logic signed [65:0] td_a4_ff, td_b4_ff, tt_a4_ff, tt_b4_ff, tu_a4_ff, tu_b4_ff;
   // stage 5: cross values
   logic signed [65:0] det5_ff, tn5_ff, un5_ff;
   // stage 6: magnitudes
   logic [MW-1:0] adet6_ff, atn6_ff, aun6_ff;
   logic          tneg6_ff, uneg6_ff;
   // stage 7
   sip_tag_type   tag7_ff;
   sip_div_type   div7_ff;

   assign pd_a = mrx2_ff * msy2_ff;
   assign pd_b = mry2_ff * msx2_ff;
   assign pt_a = mwx2_ff * msy2_ff;
   assign pt_b = mwy2_ff * msx2_ff;
   assign pu_a = mwx2_ff * mry2_ff;
   assign pu_b = mwy2_ff * mrx2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rx1_ff <= $signed({bx[31], bx}) - $signed({ax[31], ax});
         ry1_ff <= $signed({by[31], by}) - $signed({ay[31], ay});
         sx1_ff <= $signed({dx[31], dx}) - $signed({cx[31], cx});
         sy1_ff <= $signed({dy[31], dy}) - $signed({cy[31], cy});
         wx1_ff <= $signed({cx[31], cx}) - $signed({ax[31], ax});
         wy1_ff <= $signed({cy[31], cy}) - $signed({ay[31], ay});
         ax1_ff <= ax;
         ay1_ff <= ay;

         mrx2_ff <= mag33(rx1_ff);
         mry2_ff <= mag33(ry1_ff);
         msx2_ff <= mag33(sx1_ff);
         msy2_ff <= mag33(sy1_ff);
         mwx2_ff <= mag33(wx1_ff);
         mwy2_ff <= mag33(wy1_ff);
         sg2_ff  <= {rx1_ff[32], ry1_ff[32], sx1_ff[32], sy1_ff[32], wx1_ff[32], wy1_ff[32]};
         c2_ff   <= '{ax: ax1_ff, ay: ay1_ff, rx: rx1_ff, ry: ry1_ff};

         // sign order: rx ry sx sy wx wy
         pd_a3_ff <= pd_a;
         pd_b3_ff <= pd_b;
         pt_a3_ff <= pt_a;
         pt_b3_ff <= pt_b;
         pu_a3_ff <= pu_a;
         pu_b3_ff <= pu_b;
         ng3_ff   <= {sg2_ff[5] ^ sg2_ff[2], sg2_ff[4] ^ sg2_ff[3],
                      sg2_ff[1] ^ sg2_ff[2], sg2_ff[0] ^ sg2_ff[3],
                      sg2_ff[1] ^ sg2_ff[4], sg2_ff[0] ^ sg2_ff[5]};
         c3_ff    <= c2_ff;

         td_a4_ff <= apply_sign(ng3_ff[5], pd_a3_ff);
         td_b4_ff <= apply_sign(ng3_ff[4], pd_b3_ff);
         tt_a4_ff <= apply_sign(ng3_ff[3], pt_a3_ff);
         tt_b4_ff <= apply_sign(ng3_ff[2], pt_b3_ff);
         tu_a4_ff <= apply_sign(ng3_ff[1], pu_a3_ff);
         tu_b4_ff <= apply_sign(ng3_ff[0], pu_b3_ff);
         c4_ff    <= c3_ff;

         det5_ff <= td_a4_ff - td_b4_ff;
         tn5_ff  <= tt_a4_ff - tt_b4_ff;
         un5_ff  <= tu_a4_ff - tu_b4_ff;
         c5_ff   <= c4_ff;

         adet6_ff <= mag66(det5_ff);
         atn6_ff  <= mag66(tn5_ff);
         aun6_ff  <= mag66(un5_ff);
         tneg6_ff <= tn5_ff[65] ^ det5_ff[65];
         uneg6_ff <= un5_ff[65] ^ det5_ff[65];
         c6_ff    <= c5_ff;

         // quotient of one or more, or negative, can never pass the band
         div7_ff <= '{den: adet6_ff, rem_t: atn6_ff, rem_u: aun6_ff, q_t: '0, q_u: '0};
         c7_ff   <= c6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag7_ff <= '0;
      end else if (adv) begin
         tag7_ff.valid    <= v_ff[5];
         tag7_ff.parallel <= (adet6_ff == '0) ||
                             ((adet6_ff[MW-1:32] == '0) && (adet6_ff[31:0] < threshold));
         tag7_ff.fail     <= tneg6_ff || uneg6_ff ||
                             (atn6_ff >= adet6_ff) || (aun6_ff >= adet6_ff);
      end
   end

   assign tag_out   = tag7_ff;
   assign carry_out = c7_ff;
   assign div_out   = div7_ff;

endmodule

`default_nettype wire

@@ rtl/core/sip_div_step.sv @@
// ----------------------------------------------------------------------------
// sip_div_step
// one registered restoring step for both the t and u quotients
// ----------------------------------------------------------------------------
`default_nettype none

module sip_div_step (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  sip_pkg::sip_tag_type   tag_in,
   input  sip_pkg::sip_carry_type carry_in,
   input  sip_pkg::sip_div_type   div_in,
   output sip_pkg::sip_tag_type   tag_out,
   output sip_pkg::sip_carry_type carry_out,
   output sip_pkg::sip_div_type   div_out
);
   import sip_pkg::*;

   sip_tag_type   tag_ff;
   sip_carry_type carry_ff;
   sip_div_type   div_ff;
   sip_div_type   div_in_c;

   logic [MW:0] sh_t, sh_u, dd_t, dd_u;
   logic        ge_t, ge_u;

   always_comb begin
      sh_t = {div_in.rem_t, 1'b0};
      sh_u = {div_in.rem_u, 1'b0};
      ge_t = sh_t >= {1'b0, div_in.den};
      ge_u = sh_u >= {1'b0, div_in.den};
      dd_t = ge_t ? sh_t - {1'b0, div_in.den} : sh_t;
      dd_u = ge_u ? sh_u - {1'b0, div_in.den} : sh_u;
      div_in_c.den   = div_in.den;
      div_in_c.rem_t = dd_t[MW-1:0];
      div_in_c.rem_u = dd_u[MW-1:0];
      div_in_c.q_t   = {div_in.q_t[QW-2:0], ge_t};
      div_in_c.q_u   = {div_in.q_u[QW-2:0], ge_u};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (adv) begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         carry_ff <= carry_in;
         div_ff   <= div_in_c;
      end
   end

   assign tag_out   = tag_ff;
   assign carry_out = carry_ff;
   assign div_out   = div_ff;

endmodule

`default_nettype wire

@@ rtl/core/sip_back.sv @@
// ----------------------------------------------------------------------------
// sip_back
// band test on t and u, point interpolation and result register (3 stages)
// ----------------------------------------------------------------------------
`default_nettype none

module sip_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire logic [14:0]         margin,
   input  sip_pkg::sip_tag_type     tag_in,
   input  sip_pkg::sip_carry_type   carry_in,
   input  sip_pkg::sip_div_type     div_in,
   output logic                     out_valid,
   output logic [1:0]               out_verdict,
   output logic signed [31:0]       out_x,
   output logic signed [31:0]       out_y
);
   import sip_pkg::*;

   logic [2:0]         v_ff;
   logic [16:0]        limit;
   logic               ok_t, ok_u;
   logic [1:0]         verdict1_ff, verdict2_ff, verdict3_ff;
   logic [QW-1:0]      t1_ff;
   sip_carry_type      c1_ff;
   logic signed [49:0] px2_ff, py2_ff;
   logic signed [31:0] ax2_ff, ay2_ff, x3_ff, y3_ff;

   // open band: margin < q < 1.0 - margin
   assign limit = 17'h10000 - {2'b00, margin};
   assign ok_t  = (div_in.q_t != '0) && ({1'b0, div_in.q_t} > {2'b00, margin}) &&
                  ({1'b0, div_in.q_t} < limit);
   assign ok_u  = (div_in.q_u != '0) && ({1'b0, div_in.q_u} > {2'b00, margin}) &&
                  ({1'b0, div_in.q_u} < limit);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[1:0], tag_in.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (tag_in.parallel) begin
            verdict1_ff <= VERDICT_PARALLEL;
         end else if (tag_in.fail || !ok_t || !ok_u) begin
            verdict1_ff <= VERDICT_NONE;
         end else begin
            verdict1_ff <= VERDICT_CROSS;
         end
         t1_ff <= div_in.q_t;
         c1_ff <= carry_in;

         // signed product then arithmetic shift gives the floored offset
         px2_ff      <= $signed({1'b0, t1_ff}) * c1_ff.rx;
         py2_ff      <= $signed({1'b0, t1_ff}) * c1_ff.ry;
         ax2_ff      <= c1_ff.ax;
         ay2_ff      <= c1_ff.ay;
         verdict2_ff <= verdict1_ff;

         verdict3_ff <= verdict2_ff;
         x3_ff <= (verdict2_ff == VERDICT_CROSS) ? ax2_ff + px2_ff[47:16] : '0;
         y3_ff <= (verdict2_ff == VERDICT_CROSS) ? ay2_ff + py2_ff[47:16] : '0;
      end
   end

   assign out_valid   = v_ff[2];
   assign out_verdict = verdict3_ff;
   assign out_x       = x3_ff;
   assign out_y       = y3_ff;

endmodule

`default_nettype wire

@@ rtl/core/segment_intersection_point.sv @@
// ----------------------------------------------------------------------------
// segment_intersection_point
// crossing test of two fixed point segments with crossing point, pipelined
// ----------------------------------------------------------------------------
//
//   port group  direction  carries
//   req_        in         one item: endpoints A, B, C, D in q16.16
//   rsp_        out        one item: verdict and crossing point
//   csr_        in         register writes: threshold (0), margin (1)
//
// one item enters per cycle while no result waits; the pipeline holds differences,
// products and magnitudes, then 16 restoring divide steps (one quotient bit of t
// and u per stage), then band test, interpolation and result register.
// reset clears all valid bits and loads threshold 1, margin 0.
// a result not taken holds the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_point (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [31:0] req_first_start_x,
   input  wire logic signed [31:0] req_first_start_y,
   input  wire logic signed [31:0] req_first_end_x,
   input  wire logic signed [31:0] req_first_end_y,
   input  wire logic signed [31:0] req_second_start_x,
   input  wire logic signed [31:0] req_second_start_y,
   input  wire logic signed [31:0] req_second_end_x,
   input  wire logic signed [31:0] req_second_end_y,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_verdict,
   output logic signed [31:0]      rsp_cross_x,
   output logic signed [31:0]      rsp_cross_y,
   input  wire logic               csr_we,
   input  wire logic               csr_index,
   input  wire logic [31:0]        csr_wdata
);
   import sip_pkg::*;

   `include "segment_intersection_point_macros.svh"

   // configuration registers
   logic [31:0] threshold_ff;
   logic [14:0] margin_ff;

   // whole pipeline moves together; it only holds while a result waits
   logic adv;

   sip_tag_type   tag_w   [0:DIV_LEN];
   sip_carry_type carry_w [0:DIV_LEN];
   sip_div_type   div_w   [0:DIV_LEN];

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= 32'd1;
         margin_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_ff <= csr_wdata;
            CSR_MARGIN:    margin_ff    <= csr_wdata[14:0];
            default:       threshold_ff <= threshold_ff;
         endcase
      end
   end

   // cross products and early flags
   sip_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .ax        (req_first_start_x),
      .ay        (req_first_start_y),
      .bx        (req_first_end_x),
      .by        (req_first_end_y),
      .cx        (req_second_start_x),
      .cy        (req_second_start_y),
      .dx        (req_second_end_x),
      .dy        (req_second_end_y),
      .threshold (threshold_ff),
      .tag_out   (tag_w[0]),
      .carry_out (carry_w[0]),
      .div_out   (div_w[0])
   );

   // divider chain: one quotient bit of t and of u per stage
   for (genvar g = 0; g < DIV_LEN; g++) begin : g_div
      sip_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .tag_in    (tag_w[g]),
         .carry_in  (carry_w[g]),
         .div_in    (div_w[g]),
         .tag_out   (tag_w[g+1]),
         .carry_out (carry_w[g+1]),
         .div_out   (div_w[g+1])
      );
   end

   // band test, crossing point and result register
   sip_back u_back (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .margin      (margin_ff),
      .tag_in      (tag_w[DIV_LEN]),
      .carry_in    (carry_w[DIV_LEN]),
      .div_in      (div_w[DIV_LEN]),
      .out_valid   (rsp_valid),
      .out_verdict (rsp_verdict),
      .out_x       (rsp_cross_x),
      .out_y       (rsp_cross_y)
   );

   // a point is only given with a crossing
   `SIP_ASSERT_IMP(a_point_zero, rsp_valid && (rsp_verdict != VERDICT_CROSS),
      (rsp_cross_x == '0) && (rsp_cross_y == '0), "point set without crossing")
   // verdict code is one of the three
   `SIP_ASSERT_IMP(a_verdict_code, rsp_valid,
      (rsp_verdict == VERDICT_PARALLEL) || (rsp_verdict == VERDICT_NONE) ||
      (rsp_verdict == VERDICT_CROSS), "bad verdict code")
   // a waiting result holds the input side
   `SIP_ASSERT_IMP(a_stall_input, rsp_valid && !rsp_ready, !req_ready,
      "input taken while pipeline held")
   // a held pipeline keeps its result
   `SIP_ASSERT_NXT(a_hold_result, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_verdict) && $stable(rsp_cross_x), "result lost in stall")

endmodule

`default_nettype wire

@@ sim/segment_intersection_point_tb.sv @@
// ----------------------------------------------------------------------------
// segment_intersection_point_tb
// self-checking bench: directed table then random segment pairs under several
// threshold and margin settings, with random stalls on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_point_tb;
   import sip_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;   // pipeline is 26 deep
   localparam int DUE_DEPTH = 64;      // more than the items the pipeline can hold
   localparam int ROW_DEPTH = 32;

   typedef struct packed {
      logic signed [31:0] ax, ay, bx, by, cx, cy, dx, dy;
   } segment_pair_type;

   typedef struct packed {
      logic [1:0]         verdict;
      logic signed [31:0] x;
      logic signed [31:0] y;
   } crossing_type;

   typedef struct {
      segment_pair_type pair;
      bit               typed;     // expected result written in the row
      crossing_type     result;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   segment_pair_type req_pair = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_verdict;
   logic signed [31:0] rsp_cross_x, rsp_cross_y;
   logic csr_we = 1'b0;
   logic csr_index = CSR_THRESHOLD;
   logic [31:0] csr_wdata = '0;

   // bench copy of the registers
   logic [31:0] threshold_reg = 32'd1;
   logic [14:0] margin_reg = 15'd0;

   // expectations in acceptance order, as a ring
   crossing_type crossings_due[DUE_DEPTH];
   int due_wr = 0;
   int due_rd = 0;
   table_row_type directed_rows[ROW_DEPTH];
   int row_count = 0;
   int mismatches = 0;
   int cycles = 0;
   int accepted = 0;
   bit calm = 1'b0;   // no stalls on either side while set

   segment_intersection_point i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_first_start_x  (req_pair.ax),
      .req_first_start_y  (req_pair.ay),
      .req_first_end_x    (req_pair.bx),
      .req_first_end_y    (req_pair.by),
      .req_second_start_x (req_pair.cx),
      .req_second_start_y (req_pair.cy),
      .req_second_end_x   (req_pair.dx),
      .req_second_end_y   (req_pair.dy),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_verdict        (rsp_verdict),
      .rsp_cross_x        (rsp_cross_x),
      .rsp_cross_y        (rsp_cross_y),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // generous watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("segment_intersection_point verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------

   // q16 quotient num/den truncated toward zero, tested strictly inside the band
   function automatic bit quotient_in_band(input logic signed [127:0] num,
                                           input logic signed [127:0] den,
                                           output logic [15:0] q);
      logic [127:0] mag_num, mag_den, quot;
      bit neg;
      mag_num = num[127] ? -num : num;
      mag_den = den[127] ? -den : den;
      neg = num[127] ^ den[127];
      quot = (mag_num << 16) / mag_den;
      q = '0;
      if (neg || quot == 0 || quot >= 128'd65536) return 1'b0;
      if (quot <= margin_reg || quot >= 128'd65536 - margin_reg) return 1'b0;
      q = quot[15:0];
      return 1'b1;
   endfunction

   // t*d shifted right by 16 with floor rounding
   function automatic longint lerp_offset(input logic [15:0] t, input longint d);
      longint unsigned prod;
      prod = longint'(t) * (d < 0 ? -d : d);
      if (d < 0) return -longint'((prod + 64'd65535) >> 16);
      return longint'(prod >> 16);
   endfunction

   function automatic crossing_type predict_crossing(input segment_pair_type p);
      longint rx, ry, sx, sy, wx, wy;
      logic signed [127:0] det, mag_det, t_num, u_num;
      logic [15:0] t, u;
      crossing_type res;
      rx = longint'(p.bx) - longint'(p.ax);
      ry = longint'(p.by) - longint'(p.ay);
      sx = longint'(p.dx) - longint'(p.cx);
      sy = longint'(p.dy) - longint'(p.cy);
      wx = longint'(p.cx) - longint'(p.ax);
      wy = longint'(p.cy) - longint'(p.ay);
      det = 128'(rx) * 128'(sy) - 128'(ry) * 128'(sx);
      t_num = 128'(wx) * 128'(sy) - 128'(wy) * 128'(sx);
      u_num = 128'(wx) * 128'(ry) - 128'(wy) * 128'(rx);
      mag_det = det[127] ? -det : det;
      res = '0;
      // zero determinant is parallel whatever the threshold
      if (mag_det == 0 || mag_det < 128'(threshold_reg)) begin
         res.verdict = VERDICT_PARALLEL;
         return res;
      end
      res.verdict = VERDICT_NONE;
      if (!quotient_in_band(t_num, det, t)) return res;
      if (!quotient_in_band(u_num, det, u)) return res;
      res.verdict = VERDICT_CROSS;
      res.x = 32'(longint'(p.ax) + lerp_offset(t, rx));
      res.y = 32'(longint'(p.ay) + lerp_offset(t, ry));
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   function automatic segment_pair_type make_pair(input int ax, ay, bx, by, cx, cy, dx, dy);
      segment_pair_type p;
      p = '{ax, ay, bx, by, cx, cy, dx, dy};
      return p;
   endfunction

   task automatic add_row(input segment_pair_type p, input bit typed,
                          input logic [1:0] v, input int x, input int y);
      table_row_type row;
      row.pair = p;
      row.typed = typed;
      row.result = '{v, x, y};
      directed_rows[row_count] = row;
      row_count++;
   endtask

   function automatic int small_coord(input int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   function automatic segment_pair_type random_pair();
      segment_pair_type p;
      int kind, mx, my, vx, vy, rx, ry;
      kind = $urandom_range(99);
      if (kind < 20) begin
         // full-range noise, every bit toggles
         p = {$urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
      end else if (kind < 55) begin
         // crossing by construction: both segments share their midpoint
         mx = small_coord(1 << 24); my = small_coord(1 << 24);
         rx = small_coord(1 << 20); ry = small_coord(1 << 20);
         vx = small_coord(1 << 20); vy = small_coord(1 << 20);
         p = make_pair(mx - rx, my - ry, mx + rx, my + ry,
                       mx + vx, my + vy, mx - vx, my - vy);
      end else if (kind < 70) begin
         // parallel or collinear: same direction vector
         p.ax = small_coord(1 << 22); p.ay = small_coord(1 << 22);
         p.bx = small_coord(1 << 22); p.by = small_coord(1 << 22);
         p.cx = small_coord(1 << 22); p.cy = small_coord(1 << 22);
         p.dx = p.cx + (p.bx - p.ax);
         p.dy = p.cy + (p.by - p.ay);
      end else if (kind < 80) begin
         // tiny coordinates, determinant near the threshold
         p = make_pair(small_coord(8), small_coord(8), small_coord(8), small_coord(8),
                       small_coord(8), small_coord(8), small_coord(8), small_coord(8));
      end else begin
         p = make_pair(small_coord(1 << 20), small_coord(1 << 20),
                       small_coord(1 << 20), small_coord(1 << 20),
                       small_coord(1 << 20), small_coord(1 << 20),
                       small_coord(1 << 20), small_coord(1 << 20));
      end
      return p;
   endfunction

   function automatic bit stall_now();
      return !calm && $urandom_range(99) < 37;
   endfunction

   // one item on the request channel; the expectation is stored on acceptance
   task automatic send_pair(input segment_pair_type p, input bit typed,
                            input crossing_type want);
      while (1) begin
         @(negedge clock);
         if (stall_now()) begin
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_pair <= p;
            do @(posedge clock); while (!req_ready);
            crossings_due[due_wr % DUE_DEPTH] = typed ? want : predict_crossing(p);
            due_wr++;
            accepted++;
            calm = accepted >= 450 && accepted < 650;
            return;
         end
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_wr != due_rd) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_THRESHOLD) threshold_reg = data;
      else margin_reg = data[14:0];
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
      mismatches++;
   endtask

   // ------------------------------------------------------------------------
   // result side: random back-pressure, compare against the oldest expectation
   // ------------------------------------------------------------------------
   always @(negedge clock) rsp_ready <= !stall_now();

   always @(posedge clock) begin
      crossing_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_wr == due_rd) begin
            report_mismatch("unexpected item verdict", rsp_verdict, -1);
         end else begin
            want = crossings_due[due_rd % DUE_DEPTH];
            due_rd++;
            if (rsp_verdict !== want.verdict)
               report_mismatch("verdict", rsp_verdict, want.verdict);
            if (rsp_cross_x !== want.x) report_mismatch("cross_x", rsp_cross_x, want.x);
            if (rsp_cross_y !== want.y) report_mismatch("cross_y", rsp_cross_y, want.y);
         end
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   localparam int ONE = 32'h10000;
   localparam int MIN = 32'h80000000;
   localparam int MAX = 32'h7fffffff;

   logic [31:0] phase_threshold[8];
   logic [14:0] phase_margin[8];

   initial begin
      crossing_type none;
      none = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows run at the reset settings: threshold 1, margin 0
      add_row(make_pair(0, 0, 0, 0, 0, 0, 0, 0), 1, VERDICT_PARALLEL, 0, 0);
      // x shape crossing at (1,1)
      add_row(make_pair(0, 0, 2 * ONE, 2 * ONE, 0, 2 * ONE, 2 * ONE, 0), 1,
              VERDICT_CROSS, ONE, ONE);
      // parallel horizontals
      add_row(make_pair(0, 0, ONE, 0, 0, ONE, ONE, ONE), 1, VERDICT_PARALLEL, 0, 0);
      // collinear overlap
      add_row(make_pair(0, 0, 2 * ONE, 0, ONE, 0, 3 * ONE, 0), 1, VERDICT_PARALLEL, 0, 0);
      // touching at the first start point, t is zero
      add_row(make_pair(0, 0, 2 * ONE, 0, 0, -ONE, 0, ONE), 1, VERDICT_NONE, 0, 0);
      // touching at the first end point, t is one
      add_row(make_pair(0, 0, 2 * ONE, 0, 2 * ONE, -ONE, 2 * ONE, ONE), 1,
              VERDICT_NONE, 0, 0);
      // crossing beyond the end of the first segment
      add_row(make_pair(0, 0, ONE, 0, 2 * ONE, -ONE, 2 * ONE, ONE), 1, VERDICT_NONE, 0, 0);
      // crossing behind the start, negative t
      add_row(make_pair(0, 0, ONE, 0, -ONE, -ONE, -ONE, ONE), 1, VERDICT_NONE, 0, 0);
      // second segment misses, u outside
      add_row(make_pair(0, 0, 2 * ONE, 0, ONE, ONE, ONE, 2 * ONE), 1, VERDICT_NONE, 0, 0);
      // unit determinant, smallest that passes the reset threshold
      add_row(make_pair(0, 0, 1, 0, 0, 0, 0, 1), 0, 0, 0, 0);
      add_row(make_pair(0, 0, 2, 2, 0, 2, 2, 0), 0, 0, 0, 0);
      // extremes of the coordinates
      add_row(make_pair(MIN, MIN, MAX, MAX, MIN, MAX, MAX, MIN), 0, 0, 0, 0);
      add_row(make_pair(MAX, MIN, MIN, MAX, MAX, MAX, MIN, MIN), 0, 0, 0, 0);
      add_row(make_pair(MIN, MIN, MIN, MIN, MAX, MAX, MAX, MAX), 1, VERDICT_PARALLEL, 0, 0);
      add_row(make_pair(-1, -1, -1, -1, -1, -1, -1, -1), 1, VERDICT_PARALLEL, 0, 0);
      add_row(make_pair(MIN, 0, MAX, 0, 0, MIN, 0, MAX), 0, 0, 0, 0);
      add_row(make_pair(MAX, MAX, MIN, MIN, MIN, MAX, MAX, MIN), 0, 0, 0, 0);
      // negative direction, floor shift on the way down
      add_row(make_pair(3, 3, -7, -5, -7, 3, 3, -5), 0, 0, 0, 0);
      add_row(make_pair(ONE, ONE, -ONE, -ONE + 3, -ONE, ONE, ONE + 5, -ONE), 0, 0, 0, 0);
      for (int i = 0; i < row_count; i++)
         send_pair(directed_rows[i].pair, directed_rows[i].typed, directed_rows[i].result);
      drain();

      // settings for the random phases, extremes included; margin 7fff leaves only q = 0x8000 in the band
      phase_threshold = '{32'd0, 32'd1, 32'hffffffff, 32'd0,
                          $urandom, 32'd1, $urandom_range(0, 1 << 20), 32'hffffffff};
      phase_margin = '{15'd0, 15'd0, 15'd0, 15'h7fff,
                       15'($urandom_range(0, 32767)), 15'd16384,
                       15'($urandom_range(0, 200)), 15'h7fff};
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(CSR_THRESHOLD, phase_threshold[ph]);
         write_reg(CSR_MARGIN, 32'(phase_margin[ph]));
         repeat (135) send_pair(random_pair(), 0, none);
         drain();
      end

      if (mismatches == 0) begin
         $display("segment_intersection_point verification clean");
      end else begin
         $display("segment_intersection_point verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
